// ===== src/dltq_pkg.sv =====
// package for the delta list timer queue: codes, states and default sizes
`default_nettype none
package dltq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 8;
   localparam int DELAY_BITS_DEF  = 16;
   localparam int CMD_W           = 2;
   localparam int STATUS_W        = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_LEFT_SUB,
      CELL_FROM_RIGHT,
      CELL_DECREMENT
   } cell_op_type;

   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_SHIFT,
      CHAIN_DEC
   } chain_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SCAN,
      ST_EMIT,
      ST_RESPOND
   } state_type;

endpackage
`default_nettype wire

// ===== src/dltq_req_if.sv =====
// request channel: command, id and delay with valid/ready
`default_nettype none
interface dltq_req_if #(
   parameter int ID_BITS    = dltq_pkg::ID_BITS_DEF,
   parameter int DELAY_BITS = dltq_pkg::DELAY_BITS_DEF
);
   import dltq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [ID_BITS-1:0]    entry_id;
   logic [DELAY_BITS-1:0] delay;

   modport source (output valid, output command, output entry_id, output delay, input ready);
   modport sink   (input valid, input command, input entry_id, input delay, output ready);
endinterface
`default_nettype wire

// ===== src/dltq_rsp_if.sv =====
// response channel: status, released id and queue head with valid/ready
`default_nettype none
interface dltq_rsp_if #(
   parameter int ID_BITS = dltq_pkg::ID_BITS_DEF,
   parameter int CNT_W   = $clog2(dltq_pkg::QUEUE_DEPTH_DEF + 1)
);
   import dltq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                expired_valid;
   logic [ID_BITS-1:0]  expired_id;
   logic                last_of_run;
   logic                found;
   logic                head_valid;
   logic [ID_BITS-1:0]  head_id;
   logic [CNT_W-1:0]    entry_count;

   modport source (output valid, output status, output expired_valid, output expired_id,
                   output last_of_run, output found, output head_valid, output head_id,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input expired_valid, input expired_id,
                   input last_of_run, input found, input head_valid, input head_id,
                   input entry_count, output ready);
endinterface
`default_nettype wire

// ===== src/dltq_cell.sv =====
// one queue slot: id and delta, loaded from a neighbor or the new entry, or decremented in place
`default_nettype none
module dltq_cell #(
   parameter int ID_BITS    = dltq_pkg::ID_BITS_DEF,
   parameter int DELAY_BITS = dltq_pkg::DELAY_BITS_DEF
) (
   input  wire                   clock,
   input  dltq_pkg::cell_op_type cell_op,
   input  wire [ID_BITS-1:0]     new_id,
   input  wire [DELAY_BITS-1:0]  new_delta,
   input  wire [DELAY_BITS-1:0]  sub_delta,
   input  wire [ID_BITS-1:0]     left_id,
   input  wire [DELAY_BITS-1:0]  left_delta,
   input  wire [ID_BITS-1:0]     right_id,
   input  wire [DELAY_BITS-1:0]  right_delta,
   input  wire [ID_BITS-1:0]     key_id,
   output logic [ID_BITS-1:0]    slot_id,
   output logic [DELAY_BITS-1:0] slot_delta,
   output logic                  key_match
);
   import dltq_pkg::*;

   logic [ID_BITS-1:0]    id_ff;
   logic [ID_BITS-1:0]    id_in;
   logic [DELAY_BITS-1:0] delta_ff;
   logic [DELAY_BITS-1:0] delta_in;

   always_comb begin
      id_in    = id_ff;
      delta_in = delta_ff;
      unique case (cell_op)
         CELL_HOLD: begin
            id_in    = id_ff;
            delta_in = delta_ff;
         end
         CELL_LOAD: begin
            id_in    = new_id;
            delta_in = new_delta;
         end
         CELL_FROM_LEFT: begin
            id_in    = left_id;
            delta_in = left_delta;
         end
         CELL_FROM_LEFT_SUB: begin
            id_in    = left_id;
            delta_in = left_delta - sub_delta;
         end
         CELL_FROM_RIGHT: begin
            id_in    = right_id;
            delta_in = right_delta;
         end
         CELL_DECREMENT: begin
            id_in    = id_ff;
            delta_in = (delta_ff != '0) ? delta_ff - DELAY_BITS'(1) : delta_ff;
         end
         default: begin
            id_in    = id_ff;
            delta_in = delta_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      delta_ff <= delta_in;
   end

   assign slot_id    = id_ff;
   assign slot_delta = delta_ff;
   assign key_match  = (id_ff == key_id);

endmodule
`default_nettype wire

// ===== src/delta_list_timer_queue_core.sv =====
// top level of the delta list timer queue: sequencer over a row of slot cells
// Entries sit in a row of cells ordered by expiry, each cell holding an id and
// the delta from the entry in front of it; the whole row shifts one place at
// once. An insert walks the row one cell per cycle through a single compare
// and subtract unit, then places the entry and answers. A tick on a non-empty
// queue decrements a non-zero head delta, scans the leading zero-delta entries
// to find the run, then releases them one at a time, each release going out as
// its own response transfer; when nothing is released a single response is
// sent. Remove, lookup, a tick on an empty queue and an insert into a full
// queue go straight to the response; a lookup compares all cells at once. A
// stalled response output holds the sequencer in its release or response state.
// A new request is taken only while the sequencer is idle, but a finished
// response may still be waiting. No clearing pass after reset.
`default_nettype none
module delta_list_timer_queue_core #(
   parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = dltq_pkg::ID_BITS_DEF,
   parameter int DELAY_BITS  = dltq_pkg::DELAY_BITS_DEF
) (
   input wire          clock,
   input wire          reset,
   dltq_req_if.sink    req_if,
   dltq_rsp_if.source  rsp_if
);
   import dltq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   state_type             state_ff;
   state_type             state_in;
   logic [CNT_W-1:0]      occ_ff;
   logic [CNT_W-1:0]      occ_in;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      idx_in;
   logic [DELAY_BITS-1:0] rem_ff;
   logic [DELAY_BITS-1:0] rem_in;
   logic [ID_BITS-1:0]    key_ff;
   logic [ID_BITS-1:0]    key_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic                  found_ff;
   logic                  found_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   rsp_status_in;
   logic                  rsp_exp_valid_ff;
   logic                  rsp_exp_valid_in;
   logic [ID_BITS-1:0]    rsp_exp_id_ff;
   logic [ID_BITS-1:0]    rsp_exp_id_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;
   logic                  rsp_found_ff;
   logic                  rsp_found_in;
   logic                  rsp_head_valid_ff;
   logic                  rsp_head_valid_in;
   logic [ID_BITS-1:0]    rsp_head_id_ff;
   logic [ID_BITS-1:0]    rsp_head_id_in;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic [CNT_W-1:0]      rsp_count_in;

   logic [ID_BITS-1:0]    cell_id    [QUEUE_DEPTH];
   logic [DELAY_BITS-1:0] cell_delta [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_hit;
   cell_op_type           cell_op    [QUEUE_DEPTH];
   chain_op_type          chain_op;

   logic                  req_take;
   logic                  out_free;
   logic                  load_rsp;
   logic                  idx_live;
   logic [IDX_W-1:0]      idx_sel;
   logic [ID_BITS-1:0]    id_at_idx;
   logic [DELAY_BITS-1:0] delta_at_idx;
   logic [DELAY_BITS-1:0] req_delay_fix;
   logic                  place_now;
   logic                  lookup_hit;

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_take      = req_if.valid && req_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign idx_live      = (idx_ff < occ_ff);
   assign idx_sel       = idx_ff[IDX_W-1:0];
   assign id_at_idx     = cell_id[idx_sel];
   assign delta_at_idx  = cell_delta[idx_sel];
   assign req_delay_fix = (req_if.delay == '0) ? DELAY_BITS'(1) : req_if.delay;
   assign place_now     = !idx_live || (rem_ff <= delta_at_idx);
   assign lookup_hit    = |cell_hit;

   // slot row
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      localparam logic [CNT_W-1:0] KPOS = CNT_W'(k);
      logic [ID_BITS-1:0]    lft_id;
      logic [DELAY_BITS-1:0] lft_delta;
      logic [ID_BITS-1:0]    rgt_id;
      logic [DELAY_BITS-1:0] rgt_delta;
      logic                  match;

      if (k == 0) begin : g_first
         assign lft_id    = '0;
         assign lft_delta = '0;
      end else begin : g_inner_l
         assign lft_id    = cell_id[k-1];
         assign lft_delta = cell_delta[k-1];
      end
      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign rgt_id    = '0;
         assign rgt_delta = '0;
      end else begin : g_inner_r
         assign rgt_id    = cell_id[k+1];
         assign rgt_delta = cell_delta[k+1];
      end

      always_comb begin
         cell_op[k] = CELL_HOLD;
         unique case (chain_op)
            CHAIN_HOLD:  cell_op[k] = CELL_HOLD;
            CHAIN_SHIFT: cell_op[k] = CELL_FROM_RIGHT;
            CHAIN_DEC:   cell_op[k] = (k == 0) ? CELL_DECREMENT : CELL_HOLD;
            CHAIN_INSERT: begin
               priority if (KPOS < idx_ff) begin
                  cell_op[k] = CELL_HOLD;
               end else if (KPOS == idx_ff) begin
                  cell_op[k] = CELL_LOAD;
               end else if (KPOS == idx_ff + CNT_W'(1)) begin
                  cell_op[k] = CELL_FROM_LEFT_SUB;
               end else begin
                  cell_op[k] = CELL_FROM_LEFT;
               end
            end
            default: cell_op[k] = CELL_HOLD;
         endcase
      end

      dltq_cell #(
         .ID_BITS    (ID_BITS),
         .DELAY_BITS (DELAY_BITS)
      ) u_cell (
         .clock       (clock),
         .cell_op     (cell_op[k]),
         .new_id      (key_ff),
         .new_delta   (rem_ff),
         .sub_delta   (rem_ff),
         .left_id     (lft_id),
         .left_delta  (lft_delta),
         .right_id    (rgt_id),
         .right_delta (rgt_delta),
         .key_id      (req_if.entry_id),
         .slot_id     (cell_id[k]),
         .slot_delta  (cell_delta[k]),
         .key_match   (match)
      );

      assign cell_hit[k] = match && (KPOS < occ_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority if (req_if.command == CMD_INSERT && occ_ff != DEPTH_CNT) begin
                  state_in = ST_WALK;
               end else if (req_if.command == CMD_TICK && occ_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_WALK: begin
            if (place_now) begin
               state_in = ST_RESPOND;
            end
         end
         ST_SCAN: begin
            priority if (idx_live && delta_at_idx == '0) begin
               state_in = ST_SCAN;
            end else if (idx_ff == '0) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && idx_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      chain_op          = CHAIN_HOLD;
      occ_in            = occ_ff;
      idx_in            = idx_ff;
      rem_in            = rem_ff;
      key_in            = key_ff;
      status_in         = status_ff;
      found_in          = found_ff;
      load_rsp          = 1'b0;
      rsp_status_in     = STATUS_OK;
      rsp_exp_valid_in  = 1'b0;
      rsp_exp_id_in     = '0;
      rsp_last_in       = 1'b1;
      rsp_found_in      = 1'b0;
      rsp_head_valid_in = (occ_ff != '0);
      rsp_head_id_in    = (occ_ff != '0) ? cell_id[0] : '0;
      rsp_count_in      = occ_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               status_in = STATUS_OK;
               found_in  = 1'b0;
               idx_in    = '0;
               rem_in    = req_delay_fix;
               key_in    = req_if.entry_id;
               unique case (req_if.command)
                  CMD_INSERT: begin
                     if (occ_ff == DEPTH_CNT) begin
                        status_in = STATUS_FULL;
                     end
                  end
                  CMD_TICK: begin
                     if (occ_ff != '0) begin
                        chain_op = CHAIN_DEC;
                     end
                  end
                  CMD_REMOVE: begin
                     if (occ_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        chain_op = CHAIN_SHIFT;
                        occ_in   = occ_ff - CNT_W'(1);
                     end
                  end
                  CMD_LOOKUP: found_in = lookup_hit;
                  default: found_in = 1'b0;
               endcase
            end
         end
         ST_WALK: begin
            if (place_now) begin
               chain_op = CHAIN_INSERT;
               occ_in   = occ_ff + CNT_W'(1);
            end else begin
               rem_in = rem_ff - delta_at_idx;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            if (idx_live && delta_at_idx == '0) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_rsp          = 1'b1;
               rsp_exp_valid_in  = 1'b1;
               rsp_exp_id_in     = cell_id[0];
               rsp_last_in       = (idx_ff == CNT_W'(1));
               rsp_head_valid_in = idx_live;
               rsp_head_id_in    = idx_live ? id_at_idx : '0;
               rsp_count_in      = occ_ff - idx_ff;
               chain_op          = CHAIN_SHIFT;
               occ_in            = occ_ff - CNT_W'(1);
               idx_in            = idx_ff - CNT_W'(1);
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
            end
         end
         default: chain_op = CHAIN_HOLD;
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (load_rsp) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_exp_valid_ff  <= rsp_exp_valid_in;
         rsp_exp_id_ff     <= rsp_exp_id_in;
         rsp_last_ff       <= rsp_last_in;
         rsp_found_ff      <= rsp_found_in;
         rsp_head_valid_ff <= rsp_head_valid_in;
         rsp_head_id_ff    <= rsp_head_id_in;
         rsp_count_ff      <= rsp_count_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.expired_valid = rsp_exp_valid_ff;
   assign rsp_if.expired_id    = rsp_exp_id_ff;
   assign rsp_if.last_of_run   = rsp_last_ff;
   assign rsp_if.found         = rsp_found_ff;
   assign rsp_if.head_valid    = rsp_head_valid_ff;
   assign rsp_if.head_id       = rsp_head_id_ff;
   assign rsp_if.entry_count   = rsp_count_ff;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_CNT)
      else $error("occupancy above queue depth");

   a_walk_not_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> occ_ff < DEPTH_CNT && idx_ff <= occ_ff)
      else $error("insert walk on a full queue or past the tail");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff != '0 && idx_ff <= occ_ff)
      else $error("release count out of range");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("request transfer did not start the sequencer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> rsp_valid_ff && $stable(rsp_exp_id_ff))
      else $error("pending response dropped or overwritten");

endmodule
`default_nettype wire

// ===== tb/delta_list_timer_queue_core_test.sv =====
// testbench for delta_list_timer_queue_core: directed rows, then random traffic checked by a predictor
`timescale 1ns / 100ps
module delta_list_timer_queue_core_test;
   import dltq_pkg::*;

   localparam int DEPTH          = QUEUE_DEPTH_DEF;
   localparam int ID_W           = ID_BITS_DEF;
   localparam int DELAY_W        = DELAY_BITS_DEF;
   localparam int CNT_W          = $clog2(QUEUE_DEPTH_DEF + 1);
   localparam int RANDOM_ITEMS   = 113;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int NUM_ROWS       = 22;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [ID_W-1:0]     id;
      logic [DELAY_W-1:0]  delay;
      logic [4:0]          reps;
      logic                typed;
      logic [STATUS_W-1:0] status;
      logic                found;
      logic                head_valid;
      logic [ID_W-1:0]     head_id;
      logic [CNT_W-1:0]    count;
   } stim_row_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                expired_valid;
      logic [ID_W-1:0]     expired_id;
      logic                last_of_run;
      logic                found;
      logic                head_valid;
      logic [ID_W-1:0]     head_id;
      logic [CNT_W-1:0]    entry_count;
   } timer_rsp_type;

   logic clock;
   logic reset;

   dltq_req_if req_ch ();
   dltq_rsp_if rsp_ch ();

   delta_list_timer_queue_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic [ID_W-1:0]    sleeper_id[$];
   logic [DELAY_W-1:0] sleeper_delta[$];
   timer_rsp_type      step_rsps[$];
   timer_rsp_type      awaited_rsps[$];
   int                 error_count = 0;
   int                 sender_gap_pct = 12;
   int                 ready_stall_pct = 78;
   int                 quiet_cycles = 0;

   // after reset, extremes, ties, full store, multi-entry release, removes down to empty
   stim_row_type stim_rows[NUM_ROWS] = '{
      '{CMD_TICK,   8'h00, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_REMOVE, 8'h00, 16'h0000, 5'd1,  1'b1, STATUS_EMPTY, 1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_LOOKUP, 8'h00, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_INSERT, 8'hFF, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b1, 8'hFF, 5'd1},
      '{CMD_LOOKUP, 8'hFF, 16'hFFFF, 5'd1,  1'b1, STATUS_OK,    1'b1, 1'b1, 8'hFF, 5'd1},
      '{CMD_TICK,   8'h00, 16'h0000, 5'd1,  1'b0, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_INSERT, 8'h00, 16'hFFFF, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b1, 8'h00, 5'd1},
      '{CMD_INSERT, 8'h01, 16'hFFFF, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b1, 8'h01, 5'd2},
      '{CMD_INSERT, 8'h02, 16'h0001, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b1, 8'h02, 5'd3},
      '{CMD_INSERT, 8'h03, 16'h0001, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b1, 8'h03, 5'd4},
      '{CMD_REMOVE, 8'h00, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b1, 8'h02, 5'd3},
      '{CMD_INSERT, 8'hAA, 16'h8000, 5'd1,  1'b0, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_TICK,   8'h00, 16'h0000, 5'd1,  1'b0, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_INSERT, 8'h55, 16'h0005, 5'd13, 1'b0, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_INSERT, 8'h7E, 16'h0003, 5'd1,  1'b1, STATUS_FULL,  1'b0, 1'b1, 8'h55, 5'd16},
      '{CMD_LOOKUP, 8'h55, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b1, 1'b1, 8'h55, 5'd16},
      '{CMD_TICK,   8'h00, 16'h0000, 5'd5,  1'b0, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_LOOKUP, 8'h55, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b1, 8'hAA, 5'd3},
      '{CMD_LOOKUP, 8'h00, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b1, 1'b1, 8'hAA, 5'd3},
      '{CMD_REMOVE, 8'h00, 16'h0000, 5'd3,  1'b0, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_REMOVE, 8'h00, 16'h0000, 5'd1,  1'b1, STATUS_EMPTY, 1'b0, 1'b0, 8'h00, 5'd0},
      '{CMD_LOOKUP, 8'h01, 16'h0000, 5'd1,  1'b1, STATUS_OK,    1'b0, 1'b0, 8'h00, 5'd0}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic timer_rsp_type timer_rsp(input logic [STATUS_W-1:0] status,
                                               input logic ev, input logic [ID_W-1:0] eid,
                                               input logic hit);
      timer_rsp_type r;
      r.status        = status;
      r.expired_valid = ev;
      r.expired_id    = eid;
      r.last_of_run   = 1'b0;
      r.found         = hit;
      r.head_valid    = (sleeper_id.size() > 0);
      r.head_id       = (sleeper_id.size() > 0) ? sleeper_id[0] : '0;
      r.entry_count   = CNT_W'(sleeper_id.size());
      return r;
   endfunction

   task automatic advance_timer_list(input stim_row_type rq);
      int unsigned     sum;
      int unsigned     prefix;
      int unsigned     d;
      int              pos;
      int              i;
      logic            hit;
      logic [ID_W-1:0] released[$];
      step_rsps.delete();
      case (rq.cmd)
         CMD_INSERT: begin
            if (sleeper_id.size() >= DEPTH) begin
               step_rsps.push_back(timer_rsp(STATUS_FULL, 1'b0, '0, 1'b0));
            end else begin
               d = (rq.delay == 0) ? 1 : rq.delay;
               sum = 0;
               prefix = 0;
               pos = sleeper_id.size();
               for (i = 0; i < sleeper_id.size(); i++) begin
                  sum += sleeper_delta[i];
                  if (d <= sum) begin
                     pos = i;
                     break;
                  end
                  prefix = sum;
               end
               if (pos < sleeper_id.size())
                  sleeper_delta[pos] = sleeper_delta[pos] - DELAY_W'(d - prefix);
               sleeper_id.insert(pos, rq.id);
               sleeper_delta.insert(pos, DELAY_W'(d - prefix));
               step_rsps.push_back(timer_rsp(STATUS_OK, 1'b0, '0, 1'b0));
            end
         end
         CMD_TICK: begin
            if (sleeper_id.size() > 0) begin
               if (sleeper_delta[0] != 0) sleeper_delta[0] = sleeper_delta[0] - 1'b1;
               while (sleeper_id.size() > 0 && sleeper_delta[0] == 0) begin
                  released.push_back(sleeper_id.pop_front());
                  void'(sleeper_delta.pop_front());
               end
            end
            if (released.size() == 0)
               step_rsps.push_back(timer_rsp(STATUS_OK, 1'b0, '0, 1'b0));
            foreach (released[k])
               step_rsps.push_back(timer_rsp(STATUS_OK, 1'b1, released[k], 1'b0));
         end
         CMD_REMOVE: begin
            if (sleeper_id.size() == 0) begin
               step_rsps.push_back(timer_rsp(STATUS_EMPTY, 1'b0, '0, 1'b0));
            end else begin
               void'(sleeper_id.pop_front());
               void'(sleeper_delta.pop_front());
               step_rsps.push_back(timer_rsp(STATUS_OK, 1'b0, '0, 1'b0));
            end
         end
         default: begin
            hit = 1'b0;
            foreach (sleeper_id[k])
               if (sleeper_id[k] == rq.id) hit = 1'b1;
            step_rsps.push_back(timer_rsp(STATUS_OK, 1'b0, '0, hit));
         end
      endcase
      step_rsps[step_rsps.size() - 1].last_of_run = 1'b1;
   endtask

   task automatic send_request(input stim_row_type rq);
      timer_rsp_type typed_rsp;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= rq.cmd;
      req_ch.entry_id <= rq.id;
      req_ch.delay    <= rq.delay;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      advance_timer_list(rq);
      if (rq.typed) begin
         typed_rsp.status        = rq.status;
         typed_rsp.expired_valid = 1'b0;
         typed_rsp.expired_id    = '0;
         typed_rsp.last_of_run   = 1'b1;
         typed_rsp.found         = rq.found;
         typed_rsp.head_valid    = rq.head_valid;
         typed_rsp.head_id       = rq.head_id;
         typed_rsp.entry_count   = rq.count;
         awaited_rsps.push_back(typed_rsp);
      end else begin
         foreach (step_rsps[k]) awaited_rsps.push_back(step_rsps[k]);
      end
   endtask

   function automatic stim_row_type random_request(input int n);
      stim_row_type rq;
      int           pick;
      int           insert_pct;
      rq = '0;
      rq.reps = 5'd1;
      insert_pct = ((n / 32) % 2 == 0) ? 60 : 30;
      pick = $urandom_range(99);
      rq.id = ID_W'($urandom_range(255));
      if (pick < insert_pct) begin
         rq.cmd = CMD_INSERT;
         pick = $urandom_range(99);
         if (pick < 70)      rq.delay = DELAY_W'($urandom_range(0, 8));
         else if (pick < 90) rq.delay = DELAY_W'($urandom_range(0, 200));
         else                rq.delay = DELAY_W'($urandom_range(0, 65535));
      end else begin
         rq.delay = DELAY_W'($urandom_range(0, 65535));
         if (pick < insert_pct + 25) begin
            rq.cmd = CMD_TICK;
         end else if (pick < insert_pct + 32) begin
            rq.cmd = CMD_REMOVE;
         end else begin
            rq.cmd = CMD_LOOKUP;
            if (sleeper_id.size() > 0 && $urandom_range(1) == 1)
               rq.id = sleeper_id[$urandom_range(sleeper_id.size() - 1)];
         end
      end
      return rq;
   endfunction

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      timer_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_rsps.size() == 0) begin
            $display("%0t: unexpected transfer, expected none actual status %0h id %0h",
                     $time, rsp_ch.status, rsp_ch.expired_id);
            error_count++;
         end else begin
            want = awaited_rsps.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_ch.status));
            check_field("expired_valid", 16'(want.expired_valid), 16'(rsp_ch.expired_valid));
            check_field("expired_id", 16'(want.expired_id), 16'(rsp_ch.expired_id));
            check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_ch.last_of_run));
            check_field("found", 16'(want.found), 16'(rsp_ch.found));
            check_field("head_valid", 16'(want.head_valid), 16'(rsp_ch.head_valid));
            check_field("head_id", 16'(want.head_id), 16'(rsp_ch.head_id));
            check_field("entry_count", 16'(want.entry_count), 16'(rsp_ch.entry_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.command  <= CMD_TICK;
      req_ch.entry_id <= '0;
      req_ch.delay    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_rows[r])
         for (int k = 0; k < stim_rows[r].reps; k++) send_request(stim_rows[r]);
      for (int phase = 0; phase < 3; phase++) begin
         sender_gap_pct  = (phase == 0) ? 12 : (phase == 1) ? 78 : 0;
         ready_stall_pct = (phase == 0) ? 78 : (phase == 1) ? 12 : 0;
         for (int n = 0; n < RANDOM_ITEMS; n++) send_request(random_request(n));
      end
      req_ch.valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
